FILE: sv/lav_pkg.sv
// shared types and helpers for the look-at view matrix unit
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;

	localparam int WORD_W = 32;
	localparam int WIDE_W = 67;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} vec3_t;

	typedef struct packed {
		word_t from_x;
		word_t from_y;
		word_t from_z;
		word_t dir_x;
		word_t dir_y;
		word_t dir_z;
		word_t up_x;
		word_t up_y;
		word_t up_z;
	} in_item_t;

	typedef struct packed {
		word_t m00;
		word_t m01;
		word_t m02;
		word_t m03;
		word_t m10;
		word_t m11;
		word_t m12;
		word_t m13;
		word_t m20;
		word_t m21;
		word_t m22;
		word_t m23;
	} out_item_t;

	localparam wide_t SAT_MAX = wide_t'(64'sh7fffffff);
	localparam wide_t SAT_MIN = -wide_t'(64'sh80000000);

	function automatic word_t sat32(input wide_t v);
		word_t r;
		if (v > SAT_MAX) begin
			r = word_t'(32'sh7fffffff);
		end else if (v < SAT_MIN) begin
			r = word_t'(32'sh80000000);
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/lav_stream_if.sv
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps
`default_nettype none
interface lav_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/lav_isqrt.sv
// pipelined integer square root, one root bit per stage, with side data
`timescale 1ns / 1ps
`default_nettype none
module lav_isqrt #(
	parameter int SIDE_W = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  logic [63:0]       s,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_v,
	output logic [31:0]       root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int STAGES = 32;

	logic              v_s    [STAGES];
	logic [33:0]       rem_s  [STAGES];
	logic [31:0]       root_s [STAGES];
	logic [63:0]       rad_s  [STAGES];
	logic [SIDE_W-1:0] side_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_step
		logic              cur_v;
		logic [33:0]       cur_rem;
		logic [31:0]       cur_root;
		logic [63:0]       cur_rad;
		logic [SIDE_W-1:0] cur_side;
		logic [35:0]       t;
		logic [35:0]       trial;
		logic [35:0]       diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign cur_v    = in_v;
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_rad  = s;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_v    = v_s[k-1];
			assign cur_rem  = rem_s[k-1];
			assign cur_root = root_s[k-1];
			assign cur_rad  = rad_s[k-1];
			assign cur_side = side_s[k-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign t     = {cur_rem, cur_rad[63:62]};
		assign trial = {2'b00, cur_root, 2'b01};
		assign ge    = t >= trial;
		assign diff  = t - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[33:0] : t[33:0];
				root_s[k] <= {cur_root[30:0], ge};
				rad_s[k]  <= cur_rad << 2;
				side_s[k] <= cur_side;
			end
		end
	end

	assign out_v    = v_s[STAGES-1];
	assign root     = root_s[STAGES-1];
	assign side_out = side_s[STAGES-1];
endmodule
`default_nettype wire

FILE: sv/lav_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module lav_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [32+FRAC_BITS:0]     num,
	input  logic [31:0]               den,
	output logic [FRAC_BITS:0]        quo
);
	localparam int QW = FRAC_BITS + 1;
	localparam int NW = 32 + QW;

	logic [31:0] rem_s [QW];
	logic [QW-1:0] lo_s [QW];
	logic [QW-1:0] q_s  [QW];
	logic [31:0] den_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [31:0]   cur_rem;
		logic [QW-1:0] cur_lo;
		logic [QW-1:0] cur_q;
		logic [31:0]   cur_den;
		logic [32:0]   t;
		logic [32:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			// top part of the dividend is already below the divisor
			assign cur_rem = num[NW-1:QW];
			assign cur_lo  = num[QW-1:0];
			assign cur_q   = '0;
			assign cur_den = den;
		end else begin : g_next
			assign cur_rem = rem_s[k-1];
			assign cur_lo  = lo_s[k-1];
			assign cur_q   = q_s[k-1];
			assign cur_den = den_s[k-1];
		end

		assign t    = {cur_rem, cur_lo[QW-1]};
		assign ge   = t >= {1'b0, cur_den};
		assign diff = t - {1'b0, cur_den};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[31:0] : t[31:0];
				lo_s[k]  <= cur_lo << 1;
				q_s[k]   <= {cur_q[QW-2:0], ge};
				den_s[k] <= cur_den;
			end
		end
	end

	assign quo = q_s[QW-1];
endmodule
`default_nettype wire

FILE: sv/lav_norm.sv
// vector normalization: squares, sum, square root, three dividers, sign
`timescale 1ns / 1ps
`default_nettype none
module lav_norm #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  lav_pkg::vec3_t vin,
	output logic          out_v,
	output lav_pkg::vec3_t vout
);
	import lav_pkg::*;

	localparam int QW = FRAC_BITS + 1;
	localparam int NW = WORD_W + QW;

	typedef struct packed {
		logic       v;
		logic       zero;
		logic [2:0] sgn;
	} ctl_t;

	word_t       vi [3];
	logic        v_s1;
	word_t       vec_s1 [3];
	logic [63:0] sq_s1 [3];
	logic        v_s2;
	word_t       vec_s2 [3];
	logic [63:0] sum_s2;

	logic        sq_v;
	logic [31:0] len;
	logic [95:0] side;
	word_t       sv [3];

	logic [NW-1:0] num_s3 [3];
	logic [31:0]   len_s3;
	ctl_t          ctl_s3;
	ctl_t          ctl_d [QW];
	logic [QW-1:0] quo [3];
	logic          v_s4;
	word_t         n_s4 [3];

	assign vi[0] = vin.x;
	assign vi[1] = vin.y;
	assign vi[2] = vin.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ctl_s3 <= '0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			ctl_s3.v    <= sq_v;
			ctl_s3.zero <= len == 32'd0;
			ctl_s3.sgn  <= {sv[2][WORD_W-1], sv[1][WORD_W-1], sv[0][WORD_W-1]};
			v_s4 <= ctl_d[QW-1].v;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic signed [63:0] sq;
		logic [31:0]        mag;

		assign sq  = vi[i] * vi[i];
		assign mag = sv[i][WORD_W-1] ? 32'(-sv[i]) : 32'(sv[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s1[i] <= vi[i];
				sq_s1[i]  <= sq;
				vec_s2[i] <= vec_s1[i];
				// |v| * 2^F plus half the length rounds the quotient
				num_s3[i] <= NW'({mag, {FRAC_BITS{1'b0}}}) + NW'(len >> 1);
			end
		end

		lav_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk (clk),
			.en  (en),
			.num (num_s3[i]),
			.den (len_s3),
			.quo (quo[i])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				if (ctl_d[QW-1].zero) begin
					n_s4[i] <= '0;
				end else if (ctl_d[QW-1].sgn[i]) begin
					n_s4[i] <= -word_t'(WORD_W'(quo[i]));
				end else begin
					n_s4[i] <= word_t'(WORD_W'(quo[i]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			len_s3 <= len;
		end
	end

	lav_isqrt #(.SIDE_W(96)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s2),
		.s        (sum_s2),
		.side_in  ({vec_s2[0], vec_s2[1], vec_s2[2]}),
		.out_v    (sq_v),
		.root     (len),
		.side_out (side)
	);

	assign sv[0] = side[95:64];
	assign sv[1] = side[63:32];
	assign sv[2] = side[31:0];

	// sign and zero flags ride along with the dividers
	for (genvar k = 0; k < QW; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_d[k] <= '0;
			end else if (en) begin
				ctl_d[k] <= (k == 0) ? ctl_s3 : ctl_d[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign out_v  = v_s4;
	assign vout.x = n_s4[0];
	assign vout.y = n_s4[1];
	assign vout.z = n_s4[2];
endmodule
`default_nettype wire

FILE: sv/lav_xform.sv
// cross products, translation dot products and saturation of the view rows
`timescale 1ns / 1ps
`default_nettype none
module lav_xform #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  lav_pkg::vec3_t     dir,
	input  lav_pkg::vec3_t     up,
	input  lav_pkg::vec3_t     from,
	output logic               out_v,
	output lav_pkg::out_item_t res
);
	import lav_pkg::*;

	localparam wide_t HALF = wide_t'(1) <<< (FRAC_BITS - 1);

	function automatic word_t rnd_sat(input wide_t v);
		wide_t r;
		r = (v + HALF) >>> FRAC_BITS;
		return sat32(r);
	endfunction

	function automatic word_t neg_rnd_sat(input wide_t v);
		wide_t r;
		r = (v + HALF) >>> FRAC_BITS;
		return sat32(-r);
	endfunction

	word_t d [3];
	word_t u [3];
	word_t f [3];

	logic v_x1, v_x2, v_x3, v_x4, v_x5, v_x6, v_x7;

	logic signed [63:0] pa_x1 [3];
	logic signed [63:0] pb_x1 [3];
	word_t dir_x1 [3];
	word_t from_x1 [3];

	word_t left_x2 [3];
	word_t back_x2 [3];
	word_t dir_x2 [3];
	word_t from_x2 [3];

	logic signed [63:0] pa_x3 [3];
	logic signed [63:0] pb_x3 [3];
	logic signed [63:0] plf_x3 [3];
	logic signed [63:0] pbf_x3 [3];
	word_t left_x3 [3];
	word_t back_x3 [3];
	word_t from_x3 [3];

	word_t tup_x4 [3];
	wide_t sl_x4;
	wide_t sb_x4;
	word_t left_x4 [3];
	word_t back_x4 [3];
	word_t from_x4 [3];

	logic signed [63:0] ptf_x5 [3];
	word_t m03_x5;
	word_t m23_x5;
	word_t left_x5 [3];
	word_t back_x5 [3];
	word_t tup_x5 [3];

	wide_t st_x6;
	word_t m03_x6;
	word_t m23_x6;
	word_t left_x6 [3];
	word_t back_x6 [3];
	word_t tup_x6 [3];

	out_item_t res_x7;

	assign d[0] = dir.x;
	assign d[1] = dir.y;
	assign d[2] = dir.z;
	assign u[0] = up.x;
	assign u[1] = up.y;
	assign u[2] = up.z;
	assign f[0] = from.x;
	assign f[1] = from.y;
	assign f[2] = from.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_x1 <= 1'b0;
			v_x2 <= 1'b0;
			v_x3 <= 1'b0;
			v_x4 <= 1'b0;
			v_x5 <= 1'b0;
			v_x6 <= 1'b0;
			v_x7 <= 1'b0;
		end else if (en) begin
			v_x1 <= in_v;
			v_x2 <= v_x1;
			v_x3 <= v_x2;
			v_x4 <= v_x3;
			v_x5 <= v_x4;
			v_x6 <= v_x5;
			v_x7 <= v_x6;
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int A = (i + 1) % 3;
		localparam int B = (i + 2) % 3;

		logic signed [63:0] pa1, pb1, pa3, pb3, plf, pbf, ptf;

		assign pa1 = d[A] * u[B];
		assign pb1 = d[B] * u[A];
		assign pa3 = left_x2[A] * dir_x2[B];
		assign pb3 = left_x2[B] * dir_x2[A];
		assign plf = left_x2[i] * from_x2[i];
		assign pbf = back_x2[i] * from_x2[i];
		assign ptf = tup_x4[i] * from_x4[i];

		always_ff @(posedge clk) begin
			if (en) begin
				// left = dir x up
				pa_x1[i]   <= pa1;
				pb_x1[i]   <= pb1;
				dir_x1[i]  <= d[i];
				from_x1[i] <= f[i];

				left_x2[i] <= rnd_sat(wide_t'(pa_x1[i]) - wide_t'(pb_x1[i]));
				back_x2[i] <= sat32(-wide_t'(dir_x1[i]));
				dir_x2[i]  <= dir_x1[i];
				from_x2[i] <= from_x1[i];

				// true up = left x dir, plus the position products
				pa_x3[i]   <= pa3;
				pb_x3[i]   <= pb3;
				plf_x3[i]  <= plf;
				pbf_x3[i]  <= pbf;
				left_x3[i] <= left_x2[i];
				back_x3[i] <= back_x2[i];
				from_x3[i] <= from_x2[i];

				tup_x4[i]  <= rnd_sat(wide_t'(pa_x3[i]) - wide_t'(pb_x3[i]));
				left_x4[i] <= left_x3[i];
				back_x4[i] <= back_x3[i];
				from_x4[i] <= from_x3[i];

				ptf_x5[i]  <= ptf;
				left_x5[i] <= left_x4[i];
				back_x5[i] <= back_x4[i];
				tup_x5[i]  <= tup_x4[i];

				left_x6[i] <= left_x5[i];
				back_x6[i] <= back_x5[i];
				tup_x6[i]  <= tup_x5[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sl_x4 <= wide_t'(plf_x3[0]) + wide_t'(plf_x3[1]) + wide_t'(plf_x3[2]);
			sb_x4 <= wide_t'(pbf_x3[0]) + wide_t'(pbf_x3[1]) + wide_t'(pbf_x3[2]);

			m03_x5 <= neg_rnd_sat(sl_x4);
			m23_x5 <= neg_rnd_sat(sb_x4);

			st_x6  <= wide_t'(ptf_x5[0]) + wide_t'(ptf_x5[1]) + wide_t'(ptf_x5[2]);
			m03_x6 <= m03_x5;
			m23_x6 <= m23_x5;

			res_x7.m00 <= left_x6[0];
			res_x7.m01 <= left_x6[1];
			res_x7.m02 <= left_x6[2];
			res_x7.m03 <= m03_x6;
			res_x7.m10 <= tup_x6[0];
			res_x7.m11 <= tup_x6[1];
			res_x7.m12 <= tup_x6[2];
			res_x7.m13 <= neg_rnd_sat(st_x6);
			res_x7.m20 <= back_x6[0];
			res_x7.m21 <= back_x6[1];
			res_x7.m22 <= back_x6[2];
			res_x7.m23 <= m23_x6;
		end
	end

	assign out_v = v_x7;
	assign res   = res_x7;
endmodule
`default_nettype wire

FILE: sv/look_at_view_matrix_unit.sv
// look-at view matrix unit: top level with normalizers and row transform
// one request per cycle sustained while no finished result is held at the output
// the depth is set by the 32-stage square root and the FRAC_BITS+1 stage dividers
// a stalled result holds the whole pipeline; nothing is dropped or repeated
// arst_n clears every valid bit; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	lav_stream_if.sink          in,
	lav_stream_if.source        out
);
	import lav_pkg::*;

	localparam int NORM_LAT = FRAC_BITS + 37;

	logic      en;
	vec3_t     dir_in, up_in, from_in;
	vec3_t     dir_n, up_n;
	logic      norm_v;
	vec3_t     from_dl [NORM_LAT];
	logic      res_v;
	out_item_t res;

	// whole pipeline advances unless a finished result is held
	assign en       = !out.valid || out.ready;
	assign in.ready = en;

	assign from_in = '{x: in.data.from_x, y: in.data.from_y, z: in.data.from_z};
	assign dir_in  = '{x: in.data.dir_x, y: in.data.dir_y, z: in.data.dir_z};
	assign up_in   = '{x: in.data.up_x, y: in.data.up_y, z: in.data.up_z};

	lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_dir (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in.valid),
		.vin    (dir_in),
		.out_v  (norm_v),
		.vout   (dir_n)
	);

	lav_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_up (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in.valid),
		.vin    (up_in),
		.out_v  (),
		.vout   (up_n)
	);

	// position waits alongside the normalizers
	for (genvar k = 0; k < NORM_LAT; k++) begin : g_from
		always_ff @(posedge clk) begin
			if (en) begin
				from_dl[k] <= (k == 0) ? from_in : from_dl[(k == 0) ? 0 : k-1];
			end
		end
	end

	lav_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (norm_v),
		.dir    (dir_n),
		.up     (up_n),
		.from   (from_dl[NORM_LAT-1]),
		.out_v  (res_v),
		.res    (res)
	);

	assign out.valid = res_v;
	assign out.data  = res;
endmodule
`default_nettype wire

FILE: sv/lav_chk.sv
// port-level checks for the look-at view matrix unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module lav_chk #(
	parameter int FRAC_BITS = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input lav_pkg::out_item_t out_data
);
	import lav_pkg::*;

	localparam word_t ONE  = word_t'(32'sd1 <<< FRAC_BITS);
	localparam word_t MONE = -ONE;

	// input side stalls exactly when a result is held
	a_ready_coupling: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	// back row is a negated unit vector, each component within one
	a_back_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.m20 <= ONE && out_data.m20 >= MONE &&
			out_data.m21 <= ONE && out_data.m21 >= MONE &&
			out_data.m22 <= ONE && out_data.m22 >= MONE))
		else $error("back row outside unit range");
endmodule

bind look_at_view_matrix_unit lav_chk #(.FRAC_BITS(FRAC_BITS)) u_lav_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in.ready),
	.out_valid (out.valid),
	.out_ready (out.ready),
	.out_data  (out.data)
);
`default_nettype wire
